@@ design/vtfr_pkg.sv @@
// Package for the vision target frame receiver.
// Holds frame layout constants, the CRC-8 step function and shared types.
// Depends on nothing.
package vtfr_pkg;

  localparam int unsigned FrameBytes = 12;
  localparam int unsigned PosW       = 7;

  localparam logic [7:0] HdrByte0 = 8'hA5;
  localparam logic [7:0] HdrByte1 = 8'h5A;
  localparam logic [7:0] CrcPoly  = 8'h31;
  localparam logic [7:0] CrcInit  = 8'hFF;
  localparam logic [7:0] ModeAuto = 8'd1;

  localparam logic [PosW-1:0] PosHdr0  = 7'd0;
  localparam logic [PosW-1:0] PosHdr1  = 7'd1;
  localparam logic [PosW-1:0] PosMode  = 7'd2;
  localparam logic [PosW-1:0] PosPitch = 7'd3;
  localparam logic [PosW-1:0] PosYaw   = 7'd7;
  localparam logic [PosW-1:0] PosCrc   = 7'd11;
  localparam logic [PosW-1:0] PosIdle  = PosW'(FrameBytes);

  localparam logic [31:0] TimeoutReset = 32'd100;

  typedef enum logic {
    REQ_BYTE = 1'b0,
    REQ_TICK = 1'b1
  } req_type_e;

  // Outcome of the closing byte of a frame.
  typedef struct packed {
    logic        ok;
    logic        mode_auto;
    logic [31:0] pitch;
    logic [31:0] yaw;
  } frame_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

endpackage

@@ design/vision_target_frame_receiver_top.sv @@
// Vision target frame receiver.
//
// Input channel (in_valid_i / in_stall_o) carries one beat per received byte
// (req_type_i = 0, with rx_byte_i and frame_start_i) or per timer tick
// (req_type_i = 1, with elapsed_ms_i). A beat lands in an input register and is
// processed from there, a tick only once the result register can take it. A byte
// beat produces no result; a tick beat produces one result beat on the output
// channel (out_valid_o / out_stall_i) with the current target, held in the result
// register. One beat is accepted every cycle; the only hold-off is a
// tick waiting behind a stalled, still-occupied output register.
// A frame is 12 bytes: A5 5A, mode, pitch LE, yaw LE, CRC-8 (poly 0x31,
// init 0xFF) over bytes 0..10. A good frame latches pitch and yaw and restarts
// the silence timer at the next tick; the target drops once the timer exceeds
// the timeout register.
// The timeout register is written through cfg_valid_i / cfg_ready_o, always
// ready, and should be written only while the block is idle.
// Reset clears the target, the frame count and both channels; the timer and
// timeout start at 100 ms.
// Depends on vtfr_pkg and vtfr_deframer.
module vision_target_frame_receiver_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        frame_start_i,
  input  logic [31:0] elapsed_ms_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        tgt_locked_o,
  output logic        track_rdy_o,
  output logic [31:0] pitch_bits_o,
  output logic [31:0] yaw_bits_o,
  output logic [31:0] frame_tally_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);

  // Input register.
  logic        in_vld_q, in_vld_d;
  logic        req_q;
  logic [7:0]  byte_q;
  logic        start_q;
  logic [31:0] elapsed_q;

  logic        in_take, fire, is_tick, out_free;

  // Target state.
  logic [31:0] timeout_q;
  logic [31:0] pitch_q, pitch_d;
  logic [31:0] yaw_q, yaw_d;
  logic        flag_q, flag_d;
  logic [31:0] count_q, count_d;
  logic [31:0] timer_q, timer_d;
  logic        fresh_q, fresh_d;
  logic [32:0] timer_sum;

  // Result register.
  logic        out_vld_q, out_vld_d;
  logic        res_flag_q;
  logic [31:0] res_pitch_q, res_yaw_q, res_count_q;

  vtfr_pkg::frame_t frame;

  assign is_tick  = (vtfr_pkg::req_type_e'(req_q) == vtfr_pkg::REQ_TICK);
  assign out_free = !out_vld_q || !out_stall_i;
  assign fire     = in_vld_q && (!is_tick || out_free);
  assign in_stall_o = in_vld_q && !fire;
  assign in_take  = in_valid_i && !in_stall_o;
  assign in_vld_d = in_take || (in_vld_q && !fire);

  vtfr_deframer u_deframer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_en_i (fire && !is_tick),
    .byte_i    (byte_q),
    .start_i   (start_q),
    .frame_o   (frame)
  );

  always_comb begin
    pitch_d   = pitch_q;
    yaw_d     = yaw_q;
    flag_d    = flag_q;
    count_d   = count_q;
    timer_d   = timer_q;
    fresh_d   = fresh_q;
    timer_sum = {1'b0, timer_q} + {1'b0, elapsed_q};
    if (fire && !is_tick && frame.ok) begin
      pitch_d = frame.pitch;
      yaw_d   = frame.yaw;
      flag_d  = frame.mode_auto;
      count_d = count_q + 32'd1;
      fresh_d = 1'b1;
    end else if (fire && is_tick) begin
      if (fresh_q) begin
        timer_d = '0;
        fresh_d = 1'b0;
      end else if (!timer_sum[32]) begin
        timer_d = timer_sum[31:0];
      end
      if (timer_d > timeout_q) begin
        flag_d = 1'b0;
      end
    end
    out_vld_d = (fire && is_tick) || (out_vld_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      timeout_q <= vtfr_pkg::TimeoutReset;
      pitch_q   <= '0;
      yaw_q     <= '0;
      flag_q    <= 1'b0;
      count_q   <= '0;
      timer_q   <= vtfr_pkg::TimeoutReset;
      fresh_q   <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (cfg_valid_i && cfg_ready_o) begin
        timeout_q <= cfg_data_i;
      end
      pitch_q <= pitch_d;
      yaw_q   <= yaw_d;
      flag_q  <= flag_d;
      count_q <= count_d;
      timer_q <= timer_d;
      fresh_q <= fresh_d;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      req_q     <= req_type_i;
      byte_q    <= rx_byte_i;
      start_q   <= frame_start_i;
      elapsed_q <= elapsed_ms_i;
    end
    if (fire && is_tick) begin
      res_flag_q  <= flag_d;
      res_pitch_q <= pitch_d;
      res_yaw_q   <= yaw_d;
      res_count_q <= count_d;
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign out_valid_o   = out_vld_q;
  assign tgt_locked_o  = res_flag_q;
  assign track_rdy_o   = res_flag_q;
  assign pitch_bits_o  = res_pitch_q;
  assign yaw_bits_o    = res_yaw_q;
  assign frame_tally_o = res_count_q;

endmodule

@@ design/vtfr_deframer.sv @@
// Byte-level frame parser: tracks position, header, mode, pitch/yaw words and CRC-8.
// Reports a checked frame on the beat that carries its CRC byte.
// Depends on vtfr_pkg.
module vtfr_deframer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            byte_en_i,
  input  logic [7:0]      byte_i,
  input  logic            start_i,
  output vtfr_pkg::frame_t frame_o
);

  logic [vtfr_pkg::PosW-1:0] pos_q, pos_d, pos_eff;
  logic [7:0]  crc_q, crc_d, crc_eff;
  logic        hdr_q, hdr_d, hdr_eff;
  logic [7:0]  mode_q, mode_d;
  logic [31:0] pitch_q, pitch_d;
  logic [31:0] yaw_q, yaw_d;

  always_comb begin
    pos_eff = start_i ? vtfr_pkg::PosHdr0 : pos_q;
    crc_eff = start_i ? vtfr_pkg::CrcInit : crc_q;
    hdr_eff = start_i ? 1'b0 : hdr_q;

    pos_d   = pos_q;
    crc_d   = crc_q;
    hdr_d   = hdr_q;
    mode_d  = mode_q;
    pitch_d = pitch_q;
    yaw_d   = yaw_q;

    frame_o.ok        = 1'b0;
    frame_o.mode_auto = (mode_q == vtfr_pkg::ModeAuto);
    frame_o.pitch     = pitch_q;
    frame_o.yaw       = yaw_q;

    if (byte_en_i) begin
      pos_d = pos_eff;
      crc_d = crc_eff;
      hdr_d = hdr_eff;
      if (pos_eff < vtfr_pkg::PosIdle) begin
        if (pos_eff == vtfr_pkg::PosHdr0) begin
          hdr_d = (byte_i == vtfr_pkg::HdrByte0);
        end else if (pos_eff == vtfr_pkg::PosHdr1) begin
          hdr_d = hdr_eff && (byte_i == vtfr_pkg::HdrByte1);
        end else if (pos_eff == vtfr_pkg::PosMode) begin
          mode_d = byte_i;
        end else if (pos_eff >= vtfr_pkg::PosPitch && pos_eff < vtfr_pkg::PosYaw) begin
          pitch_d = {byte_i, pitch_q[31:8]};
        end else if (pos_eff >= vtfr_pkg::PosYaw && pos_eff < vtfr_pkg::PosCrc) begin
          yaw_d = {byte_i, yaw_q[31:8]};
        end
        if (pos_eff < vtfr_pkg::PosCrc) begin
          crc_d = vtfr_pkg::crc8_byte(crc_eff, byte_i);
        end else if (pos_eff == vtfr_pkg::PosCrc) begin
          // Mode is known good only as 0 or 1.
          frame_o.ok = hdr_eff && (mode_q <= vtfr_pkg::ModeAuto) && (byte_i == crc_eff);
        end
        pos_d = pos_eff + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= vtfr_pkg::PosIdle;
      crc_q   <= vtfr_pkg::CrcInit;
      hdr_q   <= 1'b0;
      mode_q  <= '0;
      pitch_q <= '0;
      yaw_q   <= '0;
    end else begin
      pos_q   <= pos_d;
      crc_q   <= crc_d;
      hdr_q   <= hdr_d;
      mode_q  <= mode_d;
      pitch_q <= pitch_d;
      yaw_q   <= yaw_d;
    end
  end

endmodule
